@@ hdl/dst_pkg.sv @@
package dst_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  // Number of slots that the slot field can name.
  localparam int unsigned ADDR_SLOTS = 1 << SLOT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_BAD    = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;  // capture the accepted item
    logic exec;     // carry out the held command and load the result
  } dp_cmd_t;

endpackage

@@ hdl/dst_ctrl.sv @@
module dst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output dst_pkg::dp_cmd_t   dp_cmd
);

  dst_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dst_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    dp_cmd.load_in = 1'b0;
    dp_cmd.exec    = 1'b0;
    // The held result leaves when the receiver takes it.
    out_valid_nxt  = out_valid_r && out_stall;
    unique case (state_r)
      dst_pkg::S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load_in = 1'b1;
          state_nxt      = dst_pkg::S_EXEC;
        end
      end
      dst_pkg::S_EXEC: begin
        // Finish only once the output register is free or draining.
        if (!out_valid_r || !out_stall) begin
          dp_cmd.exec   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dst_pkg::S_IDLE;
        end
      end
      default: state_nxt = dst_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != dst_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hdl/dst_datapath.sv @@
module dst_datapath #(
  parameter int SLOT_COUNT   = 16,
  parameter int BUFFER_WORDS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dst_pkg::dp_cmd_t                     dp_cmd,
  input  logic [dst_pkg::CMD_W-1:0]            in_command,
  input  logic [dst_pkg::SLOT_W-1:0]           in_slot,
  input  logic signed [dst_pkg::WORD_W-1:0]    in_data_word,
  output logic [dst_pkg::STATUS_W-1:0]         out_status,
  output logic [dst_pkg::SLOT_W-1:0]           out_granted_slot
);

  // Slots that the slot field can reach; the rest are only ever granted.
  localparam int LOW_SLOTS = (SLOT_COUNT < int'(dst_pkg::ADDR_SLOTS)) ?
                             SLOT_COUNT : int'(dst_pkg::ADDR_SLOTS);
  localparam int LOW_IDX_W = (LOW_SLOTS > 1) ? $clog2(LOW_SLOTS) : 1;
  localparam int HI_W      = $clog2(SLOT_COUNT + 1);
  localparam int POS_W     = $clog2(BUFFER_WORDS + 1);
  localparam int BUF_IDX_W = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;

  logic [dst_pkg::CMD_W-1:0]         cmd_r;
  logic [dst_pkg::SLOT_W-1:0]        slot_r;
  logic signed [dst_pkg::WORD_W-1:0] word_r;

  logic [LOW_SLOTS-1:0] flags_r, flags_nxt;
  logic [POS_W-1:0]     pos_r   [LOW_SLOTS];
  logic [POS_W-1:0]     pos_nxt [LOW_SLOTS];
  // Next slot above the addressable range: those slots never close.
  logic [HI_W-1:0]      hi_r, hi_nxt;

  logic [dst_pkg::STATUS_W-1:0] status_r, status_c;
  logic [dst_pkg::SLOT_W-1:0]   grant_r, grant_c;

  logic signed [dst_pkg::WORD_W-1:0] buf_mem [LOW_SLOTS][BUFFER_WORDS];
  logic                              mem_we;
  logic [BUF_IDX_W-1:0]              mem_col;

  logic                 found;
  logic [LOW_IDX_W-1:0] free_idx;
  logic [LOW_IDX_W-1:0] sel;
  logic                 usable;
  logic [HI_W+3:0]      hi_ext;

  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      cmd_r  <= in_command;
      slot_r <= in_slot;
      word_r <= in_data_word;
    end
    if (dp_cmd.exec) begin
      status_r <= status_c;
      grant_r  <= grant_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      hi_r    <= HI_W'(LOW_SLOTS);
      for (int i = 0; i < LOW_SLOTS; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      flags_r <= flags_nxt;
      hi_r    <= hi_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[sel][mem_col] <= word_r;
    end
  end

  // Lowest closed slot among the addressable ones.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = LOW_SLOTS - 1; i >= 0; i--) begin
      if (!flags_r[i]) begin
        found    = 1'b1;
        free_idx = LOW_IDX_W'(i);
      end
    end
  end

  assign sel     = slot_r[LOW_IDX_W-1:0];
  assign usable  = (32'(slot_r) < SLOT_COUNT) && flags_r[sel];
  assign mem_col = pos_r[sel][BUF_IDX_W-1:0];
  assign hi_ext  = (HI_W + 4)'(hi_r);

  always_comb begin
    flags_nxt = flags_r;
    pos_nxt   = pos_r;
    hi_nxt    = hi_r;
    mem_we    = 1'b0;
    status_c  = dst_pkg::ST_BAD;
    grant_c   = '0;
    if (dp_cmd.exec) begin
      unique case (cmd_r)
        dst_pkg::CMD_OPEN: begin
          if (found) begin
            flags_nxt[free_idx] = 1'b1;
            pos_nxt[free_idx]   = '0;
            status_c            = dst_pkg::ST_OK;
            grant_c             = dst_pkg::SLOT_W'(free_idx);
          end else if (32'(hi_r) < SLOT_COUNT) begin
            hi_nxt   = hi_r + HI_W'(1);
            status_c = dst_pkg::ST_OK;
            grant_c  = hi_ext[dst_pkg::SLOT_W-1:0];
          end else begin
            status_c = dst_pkg::ST_NOFREE;
          end
        end
        dst_pkg::CMD_WRITE: begin
          if (usable) begin
            if (pos_r[sel] >= POS_W'(BUFFER_WORDS)) begin
              status_c = dst_pkg::ST_FULL;
            end else begin
              mem_we       = 1'b1;
              pos_nxt[sel] = pos_r[sel] + POS_W'(1);
              status_c     = dst_pkg::ST_OK;
            end
          end
        end
        dst_pkg::CMD_CLOSE: begin
          if (usable) begin
            flags_nxt[sel] = 1'b0;
            pos_nxt[sel]   = '0;
            status_c       = dst_pkg::ST_OK;
          end
        end
        default: status_c = dst_pkg::ST_BAD;
      endcase
    end
  end

  assign out_status       = status_r;
  assign out_granted_slot = grant_r;

endmodule

@@ hdl/descriptor_slot_table_unit.sv @@
// Descriptor slot table. Each item on the input channel is one command:
// open grants the lowest closed slot, write appends in_data_word to the
// buffer of in_slot, close releases in_slot. Every item gives exactly one
// item on the output channel carrying out_status and out_granted_slot.
// Both channels use valid and stall; an item moves on an edge where valid
// is high and stall is low.
// An item is captured on the edge it is accepted and carried out in the
// execute state once the output register is free or draining, when the
// result is loaded into that register; no new item is taken until then.
// The execute state holds the free-slot search and the read-modify-write
// of the slot's write position, which is also the buffer address.
// If the receiver stalls, the result waits in the output register; one
// further item is still accepted and held until that register is free.
// Reset (synchronous, active low) closes every slot, clears every write
// position and empties both channels; buffer contents are not cleared.
module descriptor_slot_table_unit #(
  parameter int SLOT_COUNT   = 16,
  parameter int BUFFER_WORDS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dst_pkg::CMD_W-1:0]          in_command,
  input  logic [dst_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [dst_pkg::WORD_W-1:0]  in_data_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dst_pkg::STATUS_W-1:0]       out_status,
  output logic [dst_pkg::SLOT_W-1:0]         out_granted_slot
);

  dst_pkg::dp_cmd_t dp_cmd;

  // The controller owns both handshakes and sequences capture and execute.
  dst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  // The datapath holds the slot flags, write positions and buffer memory.
  dst_datapath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .dp_cmd           (dp_cmd),
    .in_command       (in_command),
    .in_slot          (in_slot),
    .in_data_word     (in_data_word),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot)
  );

endmodule
